@@ hdl/huffman_tree_codec_unit_defines.svh @@
// huffman_tree_codec_unit_defines.svh: assertion macros shared by the codec rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef HUFFMAN_TREE_CODEC_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_CODEC_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define HTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define HTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/htc_pkg.sv @@
// htc_pkg: types and codes for the huffman tree codec
// no dependencies; used by htc_ctrl, htc_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package htc_pkg;

    // request kinds
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_BUILD  = 2'd1;
    localparam logic [1:0] REQ_ENCODE = 2'd2;
    localparam logic [1:0] REQ_DECODE = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_PENDING   = 2'd1;
    localparam logic [1:0] STAT_NOT_BUILT = 2'd2;
    localparam logic [1:0] STAT_BAD       = 2'd3;

    localparam int CODE_BITS = 15;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  leaf_index;
        logic [7:0]  symbol_in;
        logic [15:0] weight_in;
        logic        code_bit;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  symbol_out;
        logic        symbol_valid;
        logic [14:0] code_word;
        logic [3:0]  code_length;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_CHK_RD, S_CHK_CMP, S_BS_RD, S_BS_CMP, S_MERGE,
        S_MERGE2, S_ES_RD, S_ES_CMP, S_EW_RD, S_EW_STEP, S_DC_RD, S_DC_CHK,
        S_DC_SYM, S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_CAPTURE, OP_LOAD_OK, OP_RES_BAD, OP_RES_NOT_BUILT,
        OP_SCAN_START, OP_CHK_RD, OP_CHK_NEXT, OP_BUILD_FAIL, OP_BS_START,
        OP_BS_RD, OP_BS_SKIP, OP_BS_CMP, OP_MERGE, OP_MERGE2, OP_ES_RD,
        OP_ES_CMP, OP_EW_RD, OP_EW_STEP, OP_DC_RD, OP_DC_CHK, OP_DC_SYM, OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       load_bad;
        logic       tree_ready;
        logic       w_zero;
        logic       chk_last;
        logic       bs_last;
        logic       hp_j;
        logic       i_root;
        logic       match;
        logic       node_root;
        logic       child_leaf;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

@@ hdl/htc_ram.sv @@
// htc_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module htc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/htc_ctrl.sv @@
// htc_ctrl: sequencer for load, build, encode and decode requests
// depends on htc_pkg; drives htc_datapath through cmd_t
`timescale 1ns / 1ps
`default_nettype none

module htc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire htc_pkg::stat_t st,
    output htc_pkg::cmd_t      cmd
);

    htc_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = htc_pkg::OP_NOP;
        req_ready  = 1'b0;
        case (state_reg)
            htc_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = htc_pkg::OP_CAPTURE;
                    state_next = htc_pkg::S_DISPATCH;
                end
            end
            htc_pkg::S_DISPATCH:
            begin
                if (st.req_type == htc_pkg::REQ_LOAD)
                begin
                    cmd.op     = st.load_bad ? htc_pkg::OP_RES_BAD : htc_pkg::OP_LOAD_OK;
                    state_next = htc_pkg::S_FINISH;
                end
                else if (st.req_type == htc_pkg::REQ_BUILD)
                begin
                    cmd.op     = htc_pkg::OP_SCAN_START;
                    state_next = htc_pkg::S_CHK_RD;
                end
                else if (!st.tree_ready)
                begin
                    cmd.op     = htc_pkg::OP_RES_NOT_BUILT;
                    state_next = htc_pkg::S_FINISH;
                end
                else if (st.req_type == htc_pkg::REQ_ENCODE)
                begin
                    cmd.op     = htc_pkg::OP_SCAN_START;
                    state_next = htc_pkg::S_ES_RD;
                end
                else
                begin
                    state_next = htc_pkg::S_DC_RD;
                end
            end
            htc_pkg::S_CHK_RD:
            begin
                cmd.op     = htc_pkg::OP_CHK_RD;
                state_next = htc_pkg::S_CHK_CMP;
            end
            htc_pkg::S_CHK_CMP:
            begin
                if (st.w_zero)
                begin
                    cmd.op     = htc_pkg::OP_BUILD_FAIL;
                    state_next = htc_pkg::S_FINISH;
                end
                else if (st.chk_last)
                begin
                    cmd.op     = htc_pkg::OP_BS_START;
                    state_next = htc_pkg::S_BS_RD;
                end
                else
                begin
                    cmd.op     = htc_pkg::OP_CHK_NEXT;
                    state_next = htc_pkg::S_CHK_RD;
                end
            end
            htc_pkg::S_BS_RD:
            begin
                if (st.hp_j)
                begin
                    cmd.op     = htc_pkg::OP_BS_SKIP;
                    state_next = st.bs_last ? htc_pkg::S_MERGE : htc_pkg::S_BS_RD;
                end
                else
                begin
                    cmd.op     = htc_pkg::OP_BS_RD;
                    state_next = htc_pkg::S_BS_CMP;
                end
            end
            htc_pkg::S_BS_CMP:
            begin
                cmd.op     = htc_pkg::OP_BS_CMP;
                state_next = st.bs_last ? htc_pkg::S_MERGE : htc_pkg::S_BS_RD;
            end
            htc_pkg::S_MERGE:
            begin
                cmd.op     = htc_pkg::OP_MERGE;
                state_next = htc_pkg::S_MERGE2;
            end
            htc_pkg::S_MERGE2:
            begin
                cmd.op     = htc_pkg::OP_MERGE2;
                state_next = st.i_root ? htc_pkg::S_FINISH : htc_pkg::S_BS_RD;
            end
            htc_pkg::S_ES_RD:
            begin
                cmd.op     = htc_pkg::OP_ES_RD;
                state_next = htc_pkg::S_ES_CMP;
            end
            htc_pkg::S_ES_CMP:
            begin
                cmd.op = htc_pkg::OP_ES_CMP;
                if (st.match)
                begin
                    state_next = htc_pkg::S_EW_RD;
                end
                else if (st.chk_last)
                begin
                    state_next = htc_pkg::S_FINISH;
                end
                else
                begin
                    state_next = htc_pkg::S_ES_RD;
                end
            end
            htc_pkg::S_EW_RD:
            begin
                cmd.op     = htc_pkg::OP_EW_RD;
                state_next = st.node_root ? htc_pkg::S_FINISH : htc_pkg::S_EW_STEP;
            end
            htc_pkg::S_EW_STEP:
            begin
                cmd.op     = htc_pkg::OP_EW_STEP;
                state_next = htc_pkg::S_EW_RD;
            end
            htc_pkg::S_DC_RD:
            begin
                cmd.op     = htc_pkg::OP_DC_RD;
                state_next = htc_pkg::S_DC_CHK;
            end
            htc_pkg::S_DC_CHK:
            begin
                cmd.op     = htc_pkg::OP_DC_CHK;
                state_next = st.child_leaf ? htc_pkg::S_DC_SYM : htc_pkg::S_FINISH;
            end
            htc_pkg::S_DC_SYM:
            begin
                cmd.op     = htc_pkg::OP_DC_SYM;
                state_next = htc_pkg::S_FINISH;
            end
            htc_pkg::S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.op     = htc_pkg::OP_OUT;
                    state_next = htc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = htc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/htc_datapath.sv @@
// htc_datapath: tree memories, scan registers, result and output registers
// depends on htc_pkg, htc_ram and huffman_tree_codec_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_tree_codec_unit_defines.svh"

module htc_datapath #(
    parameter int MAX_SYMBOLS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire htc_pkg::cmd_t cmd,
    output htc_pkg::stat_t     st,
    input  wire htc_pkg::req_t req,
    input  wire logic          cfg_we,
    input  wire logic [4:0]    cfg_wdata,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output htc_pkg::rsp_t      rsp
);

    localparam int NODES = 2 * MAX_SYMBOLS - 1;
    localparam int NW    = $clog2(NODES);
    localparam int SW    = $clog2(MAX_SYMBOLS);
    localparam int WSUM  = WEIGHT_BITS + NW;

    logic [NW-1:0]    n_reg, pos_reg, i_reg, j_reg, a_reg, b_reg, node_reg, k_reg;
    logic [WSUM-1:0]  wa_reg, wb_reg;
    logic             a_ok_reg, b_ok_reg, ready_reg;
    logic [NODES-1:0] hp_reg;
    htc_pkg::req_t    in_reg;
    htc_pkg::rsp_t    res_reg, out_reg;
    logic             out_valid_reg;

    logic [NW-1:0]   root, n_sat, root_sat, child;
    logic [WSUM-1:0] wgt, w_rd;
    logic [NW:0]     par_rd;
    logic [NW-1:0]   left_rd, right_rd;
    logic [7:0]      sym_rd;

    // ram ports
    logic            w_we, p_we, lr_we, s_we;
    logic [NW-1:0]   w_waddr, w_raddr, p_waddr, p_raddr, lr_raddr;
    logic [WSUM-1:0] w_wdata;
    logic [NW:0]     p_wdata;
    logic [SW-1:0]   s_waddr, s_raddr;

    // derived values
    always_comb
    begin
        root  = NW'((n_reg << 1) - NW'(2));
        wgt   = WSUM'(WEIGHT_BITS'(in_reg.weight_in));
        child = in_reg.code_bit ? right_rd : left_rd;
        if (cfg_wdata < 5'd2)
        begin
            n_sat = NW'(2);
        end
        else if (32'(cfg_wdata) > MAX_SYMBOLS)
        begin
            n_sat = NW'(MAX_SYMBOLS);
        end
        else
        begin
            n_sat = NW'(cfg_wdata);
        end
        root_sat = NW'((n_sat << 1) - NW'(2));
    end

    // status toward the controller
    always_comb
    begin
        st.req_type   = in_reg.req_type;
        st.load_bad   = (32'(in_reg.leaf_index) >= 32'(n_reg)) || (wgt == '0);
        st.tree_ready = ready_reg;
        st.w_zero     = (w_rd == '0);
        st.chk_last   = (j_reg == NW'(n_reg - NW'(1)));
        st.bs_last    = (j_reg == NW'(i_reg - NW'(1)));
        st.hp_j       = hp_reg[j_reg];
        st.i_root     = (i_reg == root);
        st.match      = (sym_rd == in_reg.symbol_in);
        st.node_root  = (node_reg == root);
        st.child_leaf = (child < n_reg);
        st.out_free   = !out_valid_reg || rsp_ready;
    end

    // memory port selection
    always_comb
    begin
        w_we     = (cmd.op == htc_pkg::OP_LOAD_OK) || (cmd.op == htc_pkg::OP_MERGE);
        w_waddr  = (cmd.op == htc_pkg::OP_MERGE) ? i_reg : NW'(in_reg.leaf_index);
        w_wdata  = (cmd.op == htc_pkg::OP_MERGE) ? WSUM'(wa_reg + wb_reg) : wgt;
        w_raddr  = j_reg;
        p_we     = (cmd.op == htc_pkg::OP_MERGE) || (cmd.op == htc_pkg::OP_MERGE2);
        p_waddr  = (cmd.op == htc_pkg::OP_MERGE) ? a_reg : b_reg;
        p_wdata  = {cmd.op == htc_pkg::OP_MERGE2, i_reg};
        p_raddr  = node_reg;
        lr_we    = (cmd.op == htc_pkg::OP_MERGE);
        lr_raddr = pos_reg;
        s_we     = (cmd.op == htc_pkg::OP_LOAD_OK);
        s_waddr  = SW'(in_reg.leaf_index);
        s_raddr  = (cmd.op == htc_pkg::OP_DC_CHK) ? SW'(child) : SW'(j_reg);
    end

    htc_ram #(.WIDTH(WSUM), .DEPTH(NODES)) u_weight (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rd)
    );

    htc_ram #(.WIDTH(NW + 1), .DEPTH(NODES)) u_parent (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(par_rd)
    );

    htc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_left (
        .clk(clk), .we(lr_we), .waddr(i_reg), .wdata(a_reg),
        .raddr(lr_raddr), .rdata(left_rd)
    );

    htc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_right (
        .clk(clk), .we(lr_we), .waddr(i_reg), .wdata(b_reg),
        .raddr(lr_raddr), .rdata(right_rd)
    );

    htc_ram #(.WIDTH(8), .DEPTH(MAX_SYMBOLS)) u_symbol (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(in_reg.symbol_in),
        .raddr(s_raddr), .rdata(sym_rd)
    );

    // control registers: symbol count, tree state, decode position, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= NW'(4 > MAX_SYMBOLS ? MAX_SYMBOLS : 4);
            pos_reg       <= NW'(2 * (4 > MAX_SYMBOLS ? MAX_SYMBOLS : 4) - 2);
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                n_reg     <= n_sat;
                pos_reg   <= root_sat;
                ready_reg <= 1'b0;
            end
            else
            begin
                case (cmd.op)
                    htc_pkg::OP_LOAD_OK, htc_pkg::OP_BUILD_FAIL:
                    begin
                        ready_reg <= 1'b0;
                        pos_reg   <= root;
                    end
                    htc_pkg::OP_MERGE2:
                    begin
                        if (i_reg == root)
                        begin
                            ready_reg <= 1'b1;
                            pos_reg   <= root;
                        end
                    end
                    htc_pkg::OP_DC_CHK:
                    begin
                        pos_reg <= (child < n_reg) ? root : child;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == htc_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers and result
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            htc_pkg::OP_CAPTURE:
            begin
                in_reg  <= req;
                res_reg <= '0;
            end
            htc_pkg::OP_RES_BAD, htc_pkg::OP_BUILD_FAIL:
            begin
                res_reg.status <= htc_pkg::STAT_BAD;
            end
            htc_pkg::OP_RES_NOT_BUILT:
            begin
                res_reg.status <= htc_pkg::STAT_NOT_BUILT;
            end
            htc_pkg::OP_SCAN_START:
            begin
                j_reg <= '0;
            end
            htc_pkg::OP_CHK_NEXT, htc_pkg::OP_BS_SKIP:
            begin
                j_reg <= NW'(j_reg + NW'(1));
            end
            htc_pkg::OP_BS_START:
            begin
                i_reg    <= n_reg;
                j_reg    <= '0;
                a_ok_reg <= 1'b0;
                b_ok_reg <= 1'b0;
                hp_reg   <= '0;
            end
            htc_pkg::OP_BS_CMP:
            begin
                j_reg <= NW'(j_reg + NW'(1));
                if (!a_ok_reg || (w_rd < wa_reg))
                begin
                    b_reg    <= a_reg;
                    wb_reg   <= wa_reg;
                    b_ok_reg <= a_ok_reg;
                    a_reg    <= j_reg;
                    wa_reg   <= w_rd;
                    a_ok_reg <= 1'b1;
                end
                else if (!b_ok_reg || (w_rd < wb_reg))
                begin
                    b_reg    <= j_reg;
                    wb_reg   <= w_rd;
                    b_ok_reg <= 1'b1;
                end
            end
            htc_pkg::OP_MERGE:
            begin
                hp_reg <= hp_reg | (NODES'(1) << a_reg) | (NODES'(1) << b_reg);
            end
            htc_pkg::OP_MERGE2:
            begin
                if (i_reg != root)
                begin
                    i_reg    <= NW'(i_reg + NW'(1));
                    j_reg    <= '0;
                    a_ok_reg <= 1'b0;
                    b_ok_reg <= 1'b0;
                end
            end
            htc_pkg::OP_ES_CMP:
            begin
                if (sym_rd == in_reg.symbol_in)
                begin
                    node_reg <= j_reg;
                    k_reg    <= '0;
                end
                else
                begin
                    j_reg <= NW'(j_reg + NW'(1));
                    if (j_reg == NW'(n_reg - NW'(1)))
                    begin
                        res_reg.status <= htc_pkg::STAT_BAD;
                    end
                end
            end
            htc_pkg::OP_EW_RD:
            begin
                if (node_reg == root)
                begin
                    res_reg.code_length <= 4'(k_reg);
                end
            end
            htc_pkg::OP_EW_STEP:
            begin
                for (int b = 0; b < htc_pkg::CODE_BITS; b++)
                begin
                    if (32'(k_reg) == b)
                    begin
                        res_reg.code_word[b] <= par_rd[NW];
                    end
                end
                k_reg    <= NW'(k_reg + NW'(1));
                node_reg <= par_rd[NW-1:0];
            end
            htc_pkg::OP_DC_CHK:
            begin
                if (!(child < n_reg))
                begin
                    res_reg.status <= htc_pkg::STAT_PENDING;
                end
            end
            htc_pkg::OP_DC_SYM:
            begin
                res_reg.symbol_out   <= sym_rd;
                res_reg.symbol_valid <= 1'b1;
            end
            htc_pkg::OP_OUT:
            begin
                out_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // checks on the datapath
    `HTC_ASSERT_NOW(a_out_slot, clk, rst_n, cmd.op == htc_pkg::OP_OUT, !out_valid_reg || rsp_ready)
    `HTC_ASSERT_NOW(a_pos_inner, clk, rst_n, ready_reg, (pos_reg >= n_reg) && (pos_reg <= root))
    `HTC_ASSERT_NOW(a_merge_pair, clk, rst_n, cmd.op == htc_pkg::OP_MERGE, a_ok_reg && b_ok_reg && (a_reg != b_reg))

endmodule

`default_nettype wire

@@ hdl/huffman_tree_codec_unit.sv @@
// huffman_tree_codec_unit: top level of the huffman tree codec
// depends on htc_pkg, htc_ctrl, htc_datapath (and through it htc_ram)
//
// usage
// - req channel (req_valid/req_ready, word req) carries load, build, encode
//   and decode requests; rsp channel (rsp_valid/rsp_ready, word rsp) returns
//   exactly one result word per request
// - cfg_we/cfg_wdata writes symbol_count (saturated to 2..MAX_SYMBOLS);
//   write only while no request is in flight
// - one request at a time through a shared controller and tree memories with
//   one write port each; encode time grows with the leaf index and the code
//   length, build time with symbol_count and the nodes scanned per merge
// - req_ready is high only in idle, which the controller enters as rsp_valid
//   rises, so the next request is taken then at the earliest
// - rsp holds in an output register: a stalled receiver keeps the finished
//   word there while the next request is already taken and worked on
// - reset clears the tree built flag, sets symbol_count to 4 (MAX_SYMBOLS if
//   smaller) and the decode position to the root; leaf contents are undefined until loaded
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_codec_unit #(
    parameter int MAX_SYMBOLS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire htc_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output htc_pkg::rsp_t      rsp,
    input  wire logic          cfg_we,
    input  wire logic [4:0]    cfg_wdata
);

    htc_pkg::cmd_t  cmd;
    htc_pkg::stat_t st;

    // sequencer
    htc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .st(st), .cmd(cmd)
    );

    // tree storage and arithmetic
    htc_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st), .req(req),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

endmodule

`default_nettype wire
